[hw/rtl/robot_drive_obstacle_steering_defines.svh]
// assertion macros for the drive and obstacle steering block
// no dependencies; taken in by files that carry concurrent checks
`ifndef ROBOT_DRIVE_OBSTACLE_STEERING_DEFINES_SVH
`define ROBOT_DRIVE_OBSTACLE_STEERING_DEFINES_SVH

// same-cycle implication, off during reset
`define RDOS_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("rdos check failed");

// next-cycle implication, off during reset
`define RDOS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("rdos check failed");

`endif

[hw/rtl/rdos_pkg.sv]
// shared types and constants for the drive and obstacle steering block
// no dependencies; used by the channel interfaces, the scan unit and the top level
`default_nettype none

package rdos_pkg;

  localparam int NUM_SECTORS_DEF = 8;
  localparam int DIST_W          = 16;
  localparam int SECTOR_W        = 4;

  localparam logic [DIST_W-1:0] THRESH_RESET = 16'd500;

  // item kinds
  localparam logic KIND_DRIVE  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // drive command bytes (ascii)
  localparam logic [7:0] CMD_FWD   = 8'h55;  // U
  localparam logic [7:0] CMD_BACK  = 8'h44;  // D
  localparam logic [7:0] CMD_LEFT  = 8'h4C;  // L
  localparam logic [7:0] CMD_RIGHT = 8'h52;  // R
  localparam logic [7:0] CMD_STOP  = 8'h53;  // S
  localparam logic [7:0] CMD_AUTO  = 8'h41;  // A

  // motor direction levels
  localparam logic [3:0] DIR_FWD   = 4'd10;
  localparam logic [3:0] DIR_BACK  = 4'd5;
  localparam logic [3:0] DIR_LEFT  = 4'd15;
  localparam logic [3:0] DIR_RIGHT = 4'd0;

  typedef struct packed {
    logic                start;
    logic                wr_en;
    logic [SECTOR_W-1:0] wr_sector;
    logic [DIST_W-1:0]   wr_dist;
  } scan_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [SECTOR_W-1:0] best;
  } scan_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/rdos_if.sv]
// valid/ready channels of the drive and obstacle steering block
// depends on rdos_pkg for field widths
`default_nettype none

interface rdos_item_if import rdos_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [7:0]          command_byte;
  logic [SECTOR_W-1:0] sector;
  logic [DIST_W-1:0]   distance_mm;

  modport source (output valid, cmd, command_byte, sector, distance_mm, input ready);
  modport sink   (input valid, cmd, command_byte, sector, distance_mm, output ready);
endinterface

interface rdos_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] direction_bits;
  logic       moving;
  logic       auto_mode;
  logic       turn_valid;
  logic       turn_left;
  logic [2:0] turn_units;
  logic [2:0] best_sector;
  logic       unknown_command;

  modport source (output valid, direction_bits, moving, auto_mode, turn_valid, turn_left,
                  turn_units, best_sector, unknown_command, input ready);
  modport sink   (input valid, direction_bits, moving, auto_mode, turn_valid, turn_left,
                  turn_units, best_sector, unknown_command, output ready);
endinterface

interface rdos_cfg_if import rdos_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/rdos_scan.sv]
// sector distance store and argmax scan over sectors 1..NUM_SECTORS-1
// one comparator, one sector per cycle; depends on rdos_pkg and the defines header
`default_nettype none
`include "robot_drive_obstacle_steering_defines.svh"

module rdos_scan import rdos_pkg::*; #(
  parameter int NUM_SECTORS = NUM_SECTORS_DEF
) (
  input  wire            clk,
  input  wire            rst,
  input  wire scan_req_t req,
  output scan_rsp_t      rsp
);

  localparam int SEC_W = $clog2(NUM_SECTORS);
  localparam int IDX_W = SEC_W + 1;
  localparam logic [IDX_W-1:0] IDX_END   = IDX_W'(NUM_SECTORS);
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(2);

  logic [DIST_W-1:0] dist_mem [NUM_SECTORS];
  logic [DIST_W-1:0] top;
  logic [SEC_W-1:0]  best;
  logic [IDX_W-1:0]  idx;
  logic              busy;
  logic              done;
  logic [DIST_W-1:0] cand;

  assign cand = dist_mem[idx[SEC_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SECTORS; i++) begin
        dist_mem[i] <= '0;
      end
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.wr_en) begin
        dist_mem[req.wr_sector[SEC_W-1:0]] <= req.wr_dist;
      end
      if (req.start) begin
        // sector 1 seeds the search
        top  <= dist_mem[1];
        best <= SEC_W'(1);
        idx  <= IDX_FIRST;
        busy <= 1'b1;
      end else if (busy) begin
        if (idx == IDX_END) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          // strictly greater keeps the earliest sector on ties
          if (cand > top) begin
            top  <= cand;
            best <= idx[SEC_W-1:0];
          end
          idx <= idx + IDX_W'(1);
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.best = SECTOR_W'(best);

  `RDOS_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `RDOS_ASSERT_IMPL(a_no_restart, clk, rst, req.start, !busy)
  `RDOS_ASSERT_IMPL(a_best_range, clk, rst, done,
                    (best != '0) && ({1'b0, best} < IDX_END))
  `RDOS_ASSERT_IMPL(a_no_wr_scanned, clk, rst, busy && req.wr_en, req.wr_sector == '0)

endmodule

`default_nettype wire

[hw/rtl/robot_drive_obstacle_steering.sv]
// Drive command and obstacle steering. A drive command or a report that does not trigger
// a turn is registered into a pending word on acceptance, and that word moves to the
// output register once the output slot is free; the input is not ready until then. The
// block takes the next word once that result has moved to the output register, even if
// the consumer has not yet taken it. A front-sector report below the threshold in auto
// mode runs an argmax over the stored sector distances on a single comparator, one sector
// per cycle, so such a word keeps the input not ready through the scan and until its
// result has moved to the output register. The sector store is cleared at reset with no
// sweep. The threshold is written through the cfg channel, which is always ready.
`default_nettype none
`include "robot_drive_obstacle_steering_defines.svh"

module robot_drive_obstacle_steering import rdos_pkg::*; #(
  parameter int NUM_SECTORS = NUM_SECTORS_DEF
) (
  input  wire           clk,
  input  wire           rst,
  rdos_item_if.sink     item,
  rdos_result_if.source result,
  rdos_cfg_if.sink      cfg
);

  localparam logic [SECTOR_W:0] SEC_END  = (SECTOR_W+1)'(NUM_SECTORS);
  localparam logic [SECTOR_W:0] SEC_HALF = (SECTOR_W+1)'(NUM_SECTORS / 2);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_PUT  = 3'b100
  } state_t;

  typedef struct packed {
    logic [3:0] dir;
    logic       moving;
    logic       auto_m;
    logic       turn_valid;
    logic       turn_left;
    logic [2:0] turn_units;
    logic [2:0] best_sector;
    logic       unknown;
  } res_t;

  state_t            state;
  logic [3:0]        dir_reg;
  logic              moving_flag;
  logic              auto_flag;
  logic [DIST_W-1:0] threshold;
  res_t              pend;
  res_t              out_word;
  logic              out_valid;

  logic       take;
  logic       slot_free;
  logic       load_out;
  logic [3:0] dir_next;
  logic       moving_next;
  logic       auto_next;
  logic       unknown;
  logic       in_range;
  logic       go_scan;

  logic [SECTOR_W:0] best_x;
  logic [SECTOR_W:0] units_x;
  logic              turn_right;

  scan_req_t req;
  scan_rsp_t rsp;

  assign take      = item.valid && item.ready;
  assign slot_free = !out_valid || result.ready;
  assign load_out  = (state == ST_PUT) && slot_free;
  assign in_range  = {1'b0, item.sector} < SEC_END;

  // command decode and report handling
  always_comb begin
    dir_next    = dir_reg;
    moving_next = moving_flag;
    auto_next   = auto_flag;
    unknown     = 1'b0;
    go_scan     = 1'b0;
    if (item.cmd == KIND_DRIVE) begin
      unique case (item.command_byte)
        CMD_FWD:   begin dir_next = DIR_FWD;   moving_next = 1'b1; end
        CMD_BACK:  begin dir_next = DIR_BACK;  moving_next = 1'b1; end
        CMD_LEFT:  begin dir_next = DIR_LEFT;  moving_next = 1'b1; end
        CMD_RIGHT: begin dir_next = DIR_RIGHT; moving_next = 1'b1; end
        CMD_STOP:  begin moving_next = 1'b0; end
        CMD_AUTO:  begin
          auto_next   = 1'b1;
          dir_next    = DIR_FWD;
          moving_next = 1'b1;
        end
        default:   unknown = 1'b1;
      endcase
    end else if (in_range && auto_flag && (item.sector == '0) &&
                 (item.distance_mm < threshold)) begin
      go_scan     = 1'b1;
      dir_next    = DIR_FWD;
      moving_next = 1'b1;
    end
  end

  assign req.start     = take && go_scan;
  assign req.wr_en     = take && (item.cmd == KIND_REPORT) && in_range;
  assign req.wr_sector = item.sector;
  assign req.wr_dist   = item.distance_mm;

  rdos_scan #(
    .NUM_SECTORS(NUM_SECTORS)
  ) u_scan (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // low half turns right by s, upper half turns left by NUM_SECTORS - s
  assign best_x     = {1'b0, rsp.best};
  assign turn_right = best_x <= SEC_HALF;
  assign units_x    = turn_right ? best_x : (SEC_END - best_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      dir_reg     <= DIR_RIGHT;
      moving_flag <= 1'b0;
      auto_flag   <= 1'b0;
      threshold   <= THRESH_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        threshold <= cfg.data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            dir_reg          <= dir_next;
            moving_flag      <= moving_next;
            auto_flag        <= auto_next;
            pend.dir         <= dir_next;
            pend.moving      <= moving_next;
            pend.auto_m      <= auto_next;
            pend.turn_valid  <= 1'b0;
            pend.turn_left   <= 1'b0;
            pend.turn_units  <= '0;
            pend.best_sector <= '0;
            pend.unknown     <= unknown;
            state            <= go_scan ? ST_SCAN : ST_PUT;
          end
        end
        ST_SCAN: begin
          if (rsp.done) begin
            pend.turn_valid  <= 1'b1;
            pend.turn_left   <= !turn_right;
            pend.turn_units  <= units_x[2:0];
            pend.best_sector <= best_x[2:0];
            state            <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (slot_free) begin
            out_word <= pend;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign item.ready = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;

  assign result.valid           = out_valid;
  assign result.direction_bits  = out_word.dir;
  assign result.moving          = out_word.moving;
  assign result.auto_mode       = out_word.auto_m;
  assign result.turn_valid      = out_word.turn_valid;
  assign result.turn_left       = out_word.turn_left;
  assign result.turn_units      = out_word.turn_units;
  assign result.best_sector     = out_word.best_sector;
  assign result.unknown_command = out_word.unknown;

  `RDOS_ASSERT_NEXT(a_busy_after_take, clk, rst, take, !item.ready)
  `RDOS_ASSERT_IMPL(a_scan_only_in_scan, clk, rst, rsp.busy || rsp.done, state == ST_SCAN)
  `RDOS_ASSERT_IMPL(a_turn_leaves_fwd, clk, rst, out_valid && out_word.turn_valid,
                    out_word.moving && (out_word.dir == DIR_FWD) && out_word.auto_m)
  `RDOS_ASSERT_IMPL(a_turn_not_unknown, clk, rst, out_valid && out_word.unknown,
                    !out_word.turn_valid)

endmodule

`default_nettype wire
